// File: sv/idgl_pkg.sv
// ----------------------------------------------------------------------------
// idgl_pkg: shared definitions for the integer divide / GCD / LCM unit
// Operation codes, field widths and the sign-apply helper.
// ----------------------------------------------------------------------------
package idgl_pkg;

	localparam int OPERAND_WIDTH_DEF = 32;
	localparam int OPERAND_PORT_W    = 32;
	localparam int RESULT_W          = 64;
	localparam int REQ_W             = 3;

	localparam logic [REQ_W-1:0] OP_QUO = 3'd0;
	localparam logic [REQ_W-1:0] OP_REM = 3'd1;
	localparam logic [REQ_W-1:0] OP_MOD = 3'd2;
	localparam logic [REQ_W-1:0] OP_GCD = 3'd3;
	localparam logic [REQ_W-1:0] OP_LCM = 3'd4;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef logic [RESULT_W-1:0] result_t;

	// two's complement of a zero-extended magnitude when neg is set
	function automatic result_t apply_sign(input logic neg, input result_t mag);
		return neg ? (result_t'(0) - mag) : mag;
	endfunction

endpackage

// File: sv/integer_divide_gcd_lcm_unit_core.sv
// ----------------------------------------------------------------------------
// integer_divide_gcd_lcm_unit_core: signed divide, remainder, modulo, GCD, LCM
// One restoring divider, one quotient bit per cycle, shared by all operations
// under a small sequencer; GCD runs Euclid steps through it.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------
//  request   start, busy          req_type, operand_a, operand_b
//  result    done (one cycle)     result_value, status
//
//  A request transfers at a clock edge with start high and busy low.
//  Each divide pass runs ST_DIV once per quotient bit, then a finishing step in ST_FIN.
//  Quotient, remainder, modulo: one divide pass from transfer to done.
//  GCD: one divide pass per Euclid step, the number of steps data dependent
//  (at most about 1.45 * OPERAND_WIDTH); LCM adds one more divide pass.
//  Errors and trivial cases skip the divider. The receiver cannot stall;
//  busy stays high from transfer through the done cycle. arst_n clears control.
// ----------------------------------------------------------------------------
module integer_divide_gcd_lcm_unit_core
	import idgl_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [REQ_W-1:0]          req_type,
	input  logic [OPERAND_PORT_W-1:0] operand_a,
	input  logic [OPERAND_PORT_W-1:0] operand_b,
	output logic                      done,
	output logic [RESULT_W-1:0]       result_value,
	output logic                      status
);

	localparam int W     = OPERAND_WIDTH;
	localparam int CNT_W = $clog2(W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam logic [1:0] PH_PLAIN = 2'd0;
	localparam logic [1:0] PH_GCD   = 2'd1;
	localparam logic [1:0] PH_LCM   = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [1:0]       phase_q, phase_d;
	logic [REQ_W-1:0] op_q, op_d;
	logic             sa_q, sa_d, sb_q, sb_d;
	logic [W-1:0]     ma_q, ma_d, mb_q, mb_d;
	logic [W-1:0]     quo_q, quo_d, rem_q, rem_d, div_q, div_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	result_t          res_q, res_d;
	logic             err_q, err_d;

	logic [W-1:0]     va, vb, in_ma, in_mb;
	logic             in_sa, in_sb;
	logic [W-1:0]     shifted, mod_mag;
	logic             ge;
	logic [2*W-1:0]   prod;
	logic             start_xfer;

	assign start_xfer = start && !busy;

	// sign and magnitude of the low W bits of each operand
	always_comb begin
		va    = operand_a[W-1:0];
		vb    = operand_b[W-1:0];
		in_sa = va[W-1];
		in_sb = vb[W-1];
		in_ma = in_sa ? (~va + W'(1)) : va;
		in_mb = in_sb ? (~vb + W'(1)) : vb;
	end

	// one restoring divide step; remainder stays below 2^(W-1)
	always_comb begin
		shifted = {rem_q[W-2:0], quo_q[W-1]};
		ge      = shifted >= div_q;
		mod_mag = mb_q - rem_q;
		prod    = (2*W)'(quo_q) * (2*W)'(mb_q);
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		op_d    = op_q;
		sa_d    = sa_q;
		sb_d    = sb_q;
		ma_d    = ma_q;
		mb_d    = mb_q;
		quo_d   = quo_q;
		rem_d   = rem_q;
		div_d   = div_q;
		cnt_d   = cnt_q;
		res_d   = res_q;
		err_d   = err_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_d  = req_type;
					sa_d  = in_sa;
					sb_d  = in_sb;
					ma_d  = in_ma;
					mb_d  = in_mb;
					quo_d = in_ma;
					rem_d = '0;
					div_d = in_mb;
					cnt_d = CNT_W'(W - 1);
					res_d = '0;
					err_d = STATUS_OK;
					state_d = ST_DIV;
					case (req_type)
						OP_QUO, OP_REM, OP_MOD: begin
							phase_d = PH_PLAIN;
							if (in_mb == '0) begin
								err_d   = STATUS_ERR;
								state_d = ST_OUT;
							end
						end
						OP_GCD: begin
							phase_d = PH_GCD;
							if (in_mb == '0) begin
								res_d   = RESULT_W'(in_ma);
								state_d = ST_OUT;
							end
						end
						OP_LCM: begin
							phase_d = PH_GCD;
							if (in_ma == '0 && in_mb == '0) begin
								err_d   = STATUS_ERR;
								state_d = ST_OUT;
							end else if (in_ma == '0 || in_mb == '0) begin
								state_d = ST_OUT;
							end
						end
						default: begin
							err_d   = STATUS_ERR;
							state_d = ST_OUT;
						end
					endcase
				end
			end
			ST_DIV: begin
				quo_d = {quo_q[W-2:0], ge};
				rem_d = ge ? (shifted - div_q) : shifted;
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == '0)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				state_d = ST_OUT;
				case (phase_q)
					PH_PLAIN: begin
						case (op_q)
							OP_QUO: res_d = apply_sign(sa_q != sb_q, RESULT_W'(quo_q));
							OP_MOD: begin
								if (rem_q != '0 && sa_q != sb_q)
									res_d = apply_sign(sb_q, RESULT_W'(mod_mag));
								else
									res_d = apply_sign(sa_q, RESULT_W'(rem_q));
							end
							default: res_d = apply_sign(sa_q, RESULT_W'(rem_q));
						endcase
					end
					PH_GCD: begin
						cnt_d = CNT_W'(W - 1);
						rem_d = '0;
						if (rem_q == '0) begin
							// divisor of the last step is the GCD
							if (op_q == OP_LCM) begin
								phase_d = PH_LCM;
								quo_d   = ma_q;
								state_d = ST_DIV;
							end else begin
								res_d = RESULT_W'(div_q);
							end
						end else begin
							// next Euclid step: (y, x mod y)
							quo_d   = div_q;
							div_d   = rem_q;
							state_d = ST_DIV;
						end
					end
					default: res_d = RESULT_W'(prod);
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_PLAIN;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		sa_q  <= sa_d;
		sb_q  <= sb_d;
		ma_q  <= ma_d;
		mb_q  <= mb_d;
		quo_q <= quo_d;
		rem_q <= rem_d;
		div_q <= div_d;
		cnt_q <= cnt_d;
		res_q <= res_d;
		err_q <= err_d;
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = state_q == ST_OUT;
	assign result_value = res_q;
	assign status       = err_q;

`ifndef SYNTHESIS
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("done not followed by idle");
	a_xfer_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_xfer |=> busy)
		else $error("transfer did not start work");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_ERR) |-> result_value == '0)
		else $error("error result not zero");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> div_q != '0)
		else $error("divide pass with zero divisor");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> rem_q < div_q)
		else $error("remainder not below divisor");
`endif

endmodule
